### hw/rtl/usbdl_pkg.sv
// shared types and constants for the usb descriptor lookup
`timescale 1ns / 1ps

package usbdl_pkg;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_CONFIGURATION = 2'd0,
    KIND_INTERFACE     = 2'd1,
    KIND_ENDPOINT      = 2'd2,
    KIND_CLASS         = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_LOOKUP_KIND   = 2'd0,
    REG_TARGET_CONFIG = 2'd1,
    REG_TARGET_IFACE  = 2'd2,
    REG_TARGET_EP     = 2'd3
  } reg_e;

  localparam logic [7:0] TYPE_CONFIGURATION = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE     = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT      = 8'd5;

  localparam logic [7:0] OFS_CONFIG_VALUE = 8'd5;
  localparam logic [7:0] OFS_IFACE_NUMBER = 8'd2;
  localparam logic [7:0] OFS_IFACE_CLASS  = 8'd5;
  localparam logic [7:0] OFS_EP_ADDRESS   = 8'd2;
  localparam logic [7:0] MIN_DESC_LENGTH  = 8'd2;
  localparam logic [7:0] MIN_IFACE_LENGTH = 8'd6;
  localparam logic [7:0] EP_NUMBER_MASK   = 8'h7f;

  typedef struct packed {
    kind_e      lookup_kind;
    logic [7:0] target_configuration;
    logic [7:0] target_interface;
    logic [6:0] target_endpoint;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] desc_offset;
    logic [7:0]  class_code;
  } result_t;

endpackage

### hw/rtl/usb_descriptor_lookup.sv
// USB descriptor lookup: top level with config port, walker and result register
//
// Descriptor bytes enter on the input channel (data_byte_i, last_i with
// in_valid_i / in_ready_o), one word per byte; last_i marks the final byte
// of a buffer. One result word per buffer leaves on the output channel
// (status_o, desc_offset_o, class_code_o with out_valid_o / out_ready_i).
// The lookup kind and targets are set over the APB port before a buffer.
// Throughput is one byte per cycle while in_ready_o is high: the walker
// state is updated from the accepted byte by compares and two position
// counters in the same cycle; the result word is registered from the
// byte that decides it. Bytes after the decision are consumed and dropped
// until last_i, which clears the walker for the next buffer.
// A single result register sits on the output; while it holds a word that
// the receiver has not taken, in_ready_o is low, and it rises again in the
// cycle the receiver takes the word, so a byte can enter in that cycle too.
// Reset clears the walker, the result register and the configuration
// to its defaults.
`timescale 1ns / 1ps

module usb_descriptor_lookup #(
  parameter int MAX_BUFFER = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] desc_offset_o,
  output logic [7:0]  class_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  usbdl_pkg::cfg_t    cfg;
  usbdl_pkg::result_t result;
  usbdl_pkg::result_t result_q;
  logic               emit;
  logic               fire;
  logic               out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  usbdl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  usbdl_walker #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .cfg_i       (cfg),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
    end else if (fire && emit) begin
      result_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign desc_offset_o = result_q.desc_offset;
  assign class_code_o  = result_q.class_code;

endmodule

### hw/rtl/usbdl_regs.sv
// apb register file holding the lookup configuration
`timescale 1ns / 1ps

module usbdl_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output usbdl_pkg::cfg_t    cfg_o
);

  usbdl_pkg::cfg_t cfg_q, cfg_d;
  usbdl_pkg::reg_e sel;
  logic            wr_en;

  assign sel    = usbdl_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        usbdl_pkg::REG_LOOKUP_KIND:   cfg_d.lookup_kind = usbdl_pkg::kind_e'(pwdata[1:0]);
        usbdl_pkg::REG_TARGET_CONFIG: cfg_d.target_configuration = pwdata[7:0];
        usbdl_pkg::REG_TARGET_IFACE:  cfg_d.target_interface = pwdata[7:0];
        usbdl_pkg::REG_TARGET_EP:     cfg_d.target_endpoint = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      usbdl_pkg::REG_LOOKUP_KIND:   prdata = {30'd0, cfg_q.lookup_kind};
      usbdl_pkg::REG_TARGET_CONFIG: prdata = {24'd0, cfg_q.target_configuration};
      usbdl_pkg::REG_TARGET_IFACE:  prdata = {24'd0, cfg_q.target_interface};
      usbdl_pkg::REG_TARGET_EP:     prdata = {25'd0, cfg_q.target_endpoint};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lookup_kind          <= usbdl_pkg::KIND_CONFIGURATION;
      cfg_q.target_configuration <= 8'd1;
      cfg_q.target_interface     <= 8'd0;
      cfg_q.target_endpoint      <= 7'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/usbdl_walker.sv
// descriptor walker: tracks position, type and match flags, one byte per cycle while fire_i is high
`timescale 1ns / 1ps

module usbdl_walker #(
  parameter int MAX_BUFFER = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  input  usbdl_pkg::cfg_t      cfg_i,
  output logic                 emit_o,
  output usbdl_pkg::result_t   result_o
);

  localparam int PosW = $clog2(MAX_BUFFER + 1);

  logic [PosW-1:0] buffer_pos_q, buffer_pos_d;
  logic [PosW-1:0] desc_start_q, desc_start_d;
  logic [7:0]      pos_in_desc_q, pos_in_desc_d;
  logic [7:0]      desc_length_q, desc_length_d;
  logic [7:0]      desc_type_q, desc_type_d;
  logic            config_matched_q, config_matched_d;
  logic            interface_matched_q, interface_matched_d;
  logic            class_pending_q, class_pending_d;
  logic            answered_q, answered_d;

  always_comb begin
    logic       emit;
    logic [8:0] p_inc;
    logic [7:0] p_next;
    emit                = 1'b0;
    p_inc               = 9'd0;
    p_next              = 8'd0;
    result_o.status     = usbdl_pkg::ST_NOT_FOUND;
    result_o.desc_offset = 12'd0;
    result_o.class_code = 8'd0;
    buffer_pos_d        = buffer_pos_q;
    desc_start_d        = desc_start_q;
    pos_in_desc_d       = pos_in_desc_q;
    desc_length_d       = desc_length_q;
    desc_type_d         = desc_type_q;
    config_matched_d    = config_matched_q;
    interface_matched_d = interface_matched_q;
    class_pending_d     = class_pending_q;
    answered_d          = answered_q;

    if (fire_i && !answered_q) begin
      if (buffer_pos_q >= PosW'(MAX_BUFFER)) begin
        emit = 1'b1;
        result_o.status = usbdl_pkg::ST_MALFORMED;
      end else if (pos_in_desc_q == 8'd0) begin
        desc_start_d  = buffer_pos_q;
        desc_length_d = data_byte_i;
        desc_type_d   = 8'd0;
        if (data_byte_i < usbdl_pkg::MIN_DESC_LENGTH) begin
          emit = 1'b1;
          result_o.status = usbdl_pkg::ST_MALFORMED;
        end
      end else if (pos_in_desc_q == 8'd1) begin
        desc_type_d = data_byte_i;
      end else if (desc_type_q == usbdl_pkg::TYPE_CONFIGURATION &&
                   pos_in_desc_q == usbdl_pkg::OFS_CONFIG_VALUE) begin
        if (data_byte_i == cfg_i.target_configuration) begin
          if (cfg_i.lookup_kind == usbdl_pkg::KIND_CONFIGURATION) begin
            emit = 1'b1;
            result_o.status      = usbdl_pkg::ST_FOUND;
            result_o.desc_offset = 12'(desc_start_q);
          end else begin
            config_matched_d = 1'b1;
          end
        end
      end else if (desc_type_q == usbdl_pkg::TYPE_INTERFACE &&
                   pos_in_desc_q == usbdl_pkg::OFS_IFACE_NUMBER) begin
        if (config_matched_q && data_byte_i == cfg_i.target_interface) begin
          case (cfg_i.lookup_kind)
            usbdl_pkg::KIND_INTERFACE: begin
              emit = 1'b1;
              result_o.status      = usbdl_pkg::ST_FOUND;
              result_o.desc_offset = 12'(desc_start_q);
            end
            usbdl_pkg::KIND_ENDPOINT: interface_matched_d = 1'b1;
            usbdl_pkg::KIND_CLASS: begin
              // no room for the class byte in a short interface descriptor
              if (desc_length_q < usbdl_pkg::MIN_IFACE_LENGTH) begin
                emit = 1'b1;
                result_o.status = usbdl_pkg::ST_MALFORMED;
              end else begin
                class_pending_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end else if (desc_type_q == usbdl_pkg::TYPE_INTERFACE &&
                   pos_in_desc_q == usbdl_pkg::OFS_IFACE_CLASS) begin
        if (class_pending_q) begin
          emit = 1'b1;
          result_o.status      = usbdl_pkg::ST_FOUND;
          result_o.desc_offset = 12'(desc_start_q);
          result_o.class_code  = data_byte_i;
        end
      end else if (desc_type_q == usbdl_pkg::TYPE_ENDPOINT &&
                   pos_in_desc_q == usbdl_pkg::OFS_EP_ADDRESS) begin
        if (interface_matched_q && cfg_i.lookup_kind == usbdl_pkg::KIND_ENDPOINT &&
            (data_byte_i & usbdl_pkg::EP_NUMBER_MASK) == {1'b0, cfg_i.target_endpoint}) begin
          emit = 1'b1;
          result_o.status      = usbdl_pkg::ST_FOUND;
          result_o.desc_offset = 12'(desc_start_q);
        end
      end

      if (!emit) begin
        p_inc  = {1'b0, pos_in_desc_q} + 9'd1;
        p_next = p_inc[7:0];
        // descriptor ends: compare against the length as updated this word
        if (p_inc >= {1'b0, desc_length_d}) begin
          p_next          = 8'd0;
          class_pending_d = 1'b0;
        end
        pos_in_desc_d = p_next;
        buffer_pos_d  = buffer_pos_q + PosW'(1);
        if (last_i) begin
          emit = 1'b1;
          result_o.status = (p_next != 8'd0) ? usbdl_pkg::ST_MALFORMED
                                             : usbdl_pkg::ST_NOT_FOUND;
          result_o.desc_offset = 12'd0;
          result_o.class_code  = 8'd0;
        end
      end

      if (emit) begin
        answered_d = 1'b1;
      end
    end

    if (fire_i && last_i) begin
      buffer_pos_d        = '0;
      desc_start_d        = '0;
      pos_in_desc_d       = 8'd0;
      desc_length_d       = 8'd0;
      desc_type_d         = 8'd0;
      config_matched_d    = 1'b0;
      interface_matched_d = 1'b0;
      class_pending_d     = 1'b0;
      answered_d          = 1'b0;
    end

    emit_o = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_pos_q        <= '0;
      desc_start_q        <= '0;
      pos_in_desc_q       <= 8'd0;
      desc_length_q       <= 8'd0;
      desc_type_q         <= 8'd0;
      config_matched_q    <= 1'b0;
      interface_matched_q <= 1'b0;
      class_pending_q     <= 1'b0;
      answered_q          <= 1'b0;
    end else begin
      buffer_pos_q        <= buffer_pos_d;
      desc_start_q        <= desc_start_d;
      pos_in_desc_q       <= pos_in_desc_d;
      desc_length_q       <= desc_length_d;
      desc_type_q         <= desc_type_d;
      config_matched_q    <= config_matched_d;
      interface_matched_q <= interface_matched_d;
      class_pending_q     <= class_pending_d;
      answered_q          <= answered_d;
    end
  end

endmodule
